FILE: rtl/cwkd_pkg.sv
// cwkd_pkg: shared widths, constants and register indexes for the keying detector
// no dependencies; used by cw_key_detector_core
package cwkd_pkg;

  // slow averaging window is 2**AvgPower samples long, the fast one 2**(AvgPower-2)
  localparam int unsigned AvgPower   = 8;
  localparam int unsigned MagW       = 12;
  localparam int unsigned SumW       = AvgPower + MagW;
  localparam int unsigned CountW     = AvgPower + 1;
  localparam int unsigned PersistW   = 8;
  localparam int unsigned DurW       = 15;

  localparam logic [MagW-1:0]     MagMax      = {MagW{1'b1}};
  localparam logic [DurW-1:0]     IntervalMax = {DurW{1'b1}};
  localparam logic [PersistW-1:0] PersistMax  = {PersistW{1'b1}};

  // window lengths for the slow and the fast average
  localparam logic [CountW-1:0] LongLen  = CountW'(1 << AvgPower);
  localparam logic [CountW-1:0] ShortLen = CountW'(1 << (AvgPower - 2));

  // reset values of the registers
  localparam logic [MagW-1:0]     FloorReset   = MagW'(100);
  localparam logic [PersistW-1:0] PersistReset = PersistW'(4);

  // configuration register indexes (byte address is 4 * index)
  localparam int unsigned PaddrW = 3;
  typedef enum logic {
    REG_FLOOR   = 1'b0,
    REG_PERSIST = 1'b1
  } reg_idx_e;

endpackage

FILE: rtl/cw_key_detector_core.sv
// cw_key_detector_core: adaptive-threshold keying detector with hysteresis
// depends on cwkd_pkg for widths, constants and register indexes
//
// path: an accepted sample passes the input register and then the result register, from which
// its result leaves; throughput: one sample per cycle, stalls only on output back-pressure
// reset: rst_ni low clears all control state; thresholds return to floor 100 and 50,
// persist count to 4, key up, all counters and the window sum to zero
module cw_key_detector_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // sample stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [15:0]                  s_axis_tdata,   // [11:0] magnitude, [15:12] zero
  // interval stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [15:0]                  m_axis_tdata,   // [14:0] duration, [15] zero
  output logic                         m_axis_tuser,   // [0] is_space
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cwkd_pkg::PaddrW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  // configuration registers
  logic [cwkd_pkg::MagW-1:0]     floor_q;
  logic [cwkd_pkg::PersistW-1:0] persist_cnt_q;
  logic                          cfg_wr;
  cwkd_pkg::reg_idx_e            reg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign reg_idx = cwkd_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q       <= cwkd_pkg::FloorReset;
      persist_cnt_q <= cwkd_pkg::PersistReset;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        cwkd_pkg::REG_FLOOR:   floor_q       <= pwdata[cwkd_pkg::MagW-1:0];
        cwkd_pkg::REG_PERSIST: persist_cnt_q <= pwdata[cwkd_pkg::PersistW-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    unique case (reg_idx)
      cwkd_pkg::REG_FLOOR:   prdata = {{(32-cwkd_pkg::MagW){1'b0}}, floor_q};
      cwkd_pkg::REG_PERSIST: prdata = {{(32-cwkd_pkg::PersistW){1'b0}}, persist_cnt_q};
      default:               prdata = '0;
    endcase
  end

  // input register stage
  logic                      in_valid_q;
  logic [cwkd_pkg::MagW-1:0] mag_q;
  logic                      advance;
  logic                      out_valid_q;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      mag_q <= s_axis_tdata[cwkd_pkg::MagW-1:0];
    end
  end

  // detector state
  logic [cwkd_pkg::SumW-1:0]     sum_q, sum_d;
  logic [cwkd_pkg::CountW-1:0]   count_q, count_d;
  logic [cwkd_pkg::MagW-1:0]     down_thr_q, down_thr_d;
  logic [cwkd_pkg::MagW-1:0]     up_thr_q, up_thr_d;
  logic                          key_down_q, key_down_d;
  logic [cwkd_pkg::PersistW-1:0] pc_q, pc_d;
  logic [cwkd_pkg::DurW-1:0]     ic_q, ic_d;

  // per-sample intermediates
  logic [cwkd_pkg::SumW-1:0]     sum_acc;
  logic [cwkd_pkg::CountW-1:0]   count_inc;
  logic                          fast_mode;
  logic                          window_end;
  logic [cwkd_pkg::SumW-1:0]     level_raw;
  logic [cwkd_pkg::MagW-1:0]     level_sat;
  logic [cwkd_pkg::MagW-1:0]     level;
  logic [cwkd_pkg::MagW-1:0]     down_new;
  logic [cwkd_pkg::MagW-1:0]     up_new;
  logic [cwkd_pkg::DurW-1:0]     ic_inc;
  logic [cwkd_pkg::PersistW-1:0] pc_inc;
  logic                          persist_hit;
  logic                          emit;
  logic                          emit_space;

  // window update and threshold reload
  always_comb begin
    sum_acc   = sum_q + cwkd_pkg::SumW'(mag_q);
    count_inc = count_q + cwkd_pkg::CountW'(1);
    fast_mode = (down_thr_q <= floor_q);
    if (fast_mode) begin
      window_end = (count_inc >= cwkd_pkg::ShortLen);
      level_raw  = sum_acc >> (cwkd_pkg::AvgPower - 1);
    end else begin
      window_end = (count_inc >= cwkd_pkg::LongLen);
      level_raw  = sum_acc >> (cwkd_pkg::AvgPower + 1);
    end
    if (level_raw > cwkd_pkg::SumW'(cwkd_pkg::MagMax)) begin
      level_sat = cwkd_pkg::MagMax;
    end else begin
      level_sat = level_raw[cwkd_pkg::MagW-1:0];
    end
    level = (level_sat < floor_q) ? floor_q : level_sat;
    if (window_end) begin
      down_new = level;
      up_new   = level >> 1;
    end else begin
      down_new = down_thr_q;
      up_new   = up_thr_q;
    end
  end

  // interval and persistence counters, key decision
  always_comb begin
    ic_inc      = (ic_q < cwkd_pkg::IntervalMax) ? ic_q + cwkd_pkg::DurW'(1) : ic_q;
    pc_inc      = (pc_q < cwkd_pkg::PersistMax) ? pc_q + cwkd_pkg::PersistW'(1) : pc_q;
    persist_hit = (pc_inc >= persist_cnt_q);

    sum_d      = window_end ? '0 : sum_acc;
    count_d    = window_end ? '0 : count_inc;
    down_thr_d = down_new;
    up_thr_d   = up_new;
    key_down_d = key_down_q;
    pc_d       = '0;
    ic_d       = ic_inc;
    emit       = 1'b0;
    emit_space = 1'b0;

    if (key_down_q) begin
      if (mag_q < up_new) begin
        if (persist_hit) begin
          key_down_d = 1'b0;
          emit       = 1'b1;
          emit_space = 1'b0;
          ic_d       = '0;
        end else begin
          pc_d = pc_inc;
        end
      end
    end else begin
      if (mag_q > down_new) begin
        if (persist_hit) begin
          key_down_d = 1'b1;
          emit       = 1'b1;
          emit_space = 1'b1;
          ic_d       = '0;
          up_thr_d   = mag_q >> 1;
        end else begin
          pc_d = pc_inc;
        end
      end
    end
  end

  // state registers advance once per processed item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q      <= '0;
      count_q    <= '0;
      down_thr_q <= cwkd_pkg::FloorReset;
      up_thr_q   <= cwkd_pkg::FloorReset >> 1;
      key_down_q <= 1'b0;
      pc_q       <= '0;
      ic_q       <= '0;
    end else if (in_valid_q && advance) begin
      sum_q      <= sum_d;
      count_q    <= count_d;
      down_thr_q <= down_thr_d;
      up_thr_q   <= up_thr_d;
      key_down_q <= key_down_d;
      pc_q       <= pc_d;
      ic_q       <= ic_d;
    end
  end

  // result register
  logic [cwkd_pkg::DurW-1:0] dur_q;
  logic                      space_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q && emit) begin
      dur_q   <= ic_inc;
      space_q <= emit_space;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, dur_q};
  assign m_axis_tuser  = space_q;

endmodule

FILE: sim/tb_cw_key_detector_core.sv
// tb_cw_key_detector_core: self-checking testbench for the adaptive-threshold keying detector
// depends on rtl/cwkd_pkg.sv and rtl/cw_key_detector_core.sv; streams samples, predicts intervals
// in step with them and compares every emitted interval, with random stalls on both sides
`timescale 1ns / 100ps

module tb_cw_key_detector_core;

  localparam int DrainCycles = 8;

  typedef struct packed {
    logic                      is_space;
    logic [cwkd_pkg::DurW-1:0] duration;
  } interval_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [cwkd_pkg::PaddrW-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  cw_key_detector_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // detector shadow state
  logic [cwkd_pkg::MagW-1:0]     floor_reg;
  logic [cwkd_pkg::PersistW-1:0] persist_reg;
  logic [cwkd_pkg::SumW-1:0]     win_sum;
  logic [cwkd_pkg::CountW-1:0]   win_cnt;
  logic [cwkd_pkg::MagW-1:0]     thr_down;
  logic [cwkd_pkg::MagW-1:0]     thr_up;
  logic                          key_is_down;
  logic [cwkd_pkg::PersistW-1:0] agree_cnt;
  logic [cwkd_pkg::DurW-1:0]     run_len;

  interval_t pending_intervals[$];

  bit no_idle;
  int mismatches;
  int items_sent;
  int intervals_seen;
  int reg_writes;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // run limit
  initial begin
    #20_000_000;
    $display("timeout: %0d intervals still pending", pending_intervals.size());
    $display("CHECKS FAILED");
    $finish;
  end

  task automatic note_mismatch(input string what, input int unsigned exp_v,
                               input int unsigned act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s: expected %0d, got %0d at %0t", what, exp_v, act_v, $realtime);
  endtask

  function automatic void reset_tracker();
    floor_reg   = cwkd_pkg::FloorReset;
    persist_reg = cwkd_pkg::PersistReset;
    win_sum     = '0;
    win_cnt     = '0;
    thr_down    = cwkd_pkg::FloorReset;
    thr_up      = cwkd_pkg::FloorReset >> 1;
    key_is_down = 1'b0;
    agree_cnt   = '0;
    run_len     = '0;
  endfunction

  // advance the shadow detector by one sample, queueing any interval it ends
  function automatic void track_sample(input logic [cwkd_pkg::MagW-1:0] mag);
    logic [cwkd_pkg::SumW-1:0]   level;
    logic [cwkd_pkg::CountW-1:0] win_len;
    logic                        fast;
    interval_t                   iv;
    win_sum = win_sum + cwkd_pkg::SumW'(mag);
    win_cnt = win_cnt + 1'b1;
    fast    = (thr_down <= floor_reg);
    win_len = fast ? cwkd_pkg::ShortLen : cwkd_pkg::LongLen;
    // window end: new thresholds from the average
    if (win_cnt >= win_len) begin
      level = fast ? (win_sum >> (cwkd_pkg::AvgPower - 1))
                   : (win_sum >> (cwkd_pkg::AvgPower + 1));
      if (level > cwkd_pkg::SumW'(cwkd_pkg::MagMax)) level = cwkd_pkg::SumW'(cwkd_pkg::MagMax);
      if (level < cwkd_pkg::SumW'(floor_reg)) level = cwkd_pkg::SumW'(floor_reg);
      thr_down = level[cwkd_pkg::MagW-1:0];
      thr_up   = level[cwkd_pkg::MagW-1:0] >> 1;
      win_cnt  = '0;
      win_sum  = '0;
    end
    if (run_len != cwkd_pkg::IntervalMax) run_len = run_len + 1'b1;
    // key decision with hysteresis and persistence
    if (key_is_down ? (mag < thr_up) : (mag > thr_down)) begin
      if (agree_cnt != cwkd_pkg::PersistMax) agree_cnt = agree_cnt + 1'b1;
      if (agree_cnt >= persist_reg) begin
        iv.is_space = ~key_is_down;
        iv.duration = run_len;
        pending_intervals.push_back(iv);
        if (!key_is_down) thr_up = mag >> 1;
        key_is_down = ~key_is_down;
        run_len     = '0;
        agree_cnt   = '0;
      end
    end else begin
      agree_cnt = '0;
    end
  endfunction

  // send one magnitude item; valid stays high afterwards unless the next one idles first
  task automatic send_sample(input logic [cwkd_pkg::MagW-1:0] mag);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, mag};
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    track_sample(mag);
    items_sent++;
  endtask

  // stop sending and let every pending interval come out
  task automatic wait_intervals_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_intervals.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // register write followed by a readback
  task automatic program_reg(input cwkd_pkg::reg_idx_e idx, input logic [31:0] value);
    logic [31:0] expected;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= cwkd_pkg::PaddrW'(4 * int'(idx));
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (idx == cwkd_pkg::REG_FLOOR) floor_reg = value[cwkd_pkg::MagW-1:0];
    else persist_reg = value[cwkd_pkg::PersistW-1:0];
    reg_writes++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    expected = (idx == cwkd_pkg::REG_FLOOR) ? 32'(floor_reg) : 32'(persist_reg);
    if (prdata !== expected) note_mismatch("register readback", expected, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // alternating key-down / key-up runs around the tracked thresholds, with glitches and noise
  task automatic send_keyed_runs(input int n_items, input int noise_pct);
    int sent;
    int run;
    int k;
    int r;
    logic want_high;
    logic [cwkd_pkg::MagW-1:0] mag;
    sent = 0;
    want_high = ~key_is_down;
    while (sent < n_items) begin
      if ($urandom_range(0, 99) < 20)
        run = $urandom_range(1, (persist_reg > 0) ? int'(persist_reg) : 1);
      else
        run = int'(persist_reg) + $urandom_range(0, 2 * int'(persist_reg) + 6);
      for (k = 0; k < run && sent < n_items; k++) begin
        r = $urandom_range(0, 99);
        if (r < noise_pct)
          mag = cwkd_pkg::MagW'($urandom_range(0, 4095));
        else if (r < noise_pct + 8 && thr_down > thr_up)
          mag = cwkd_pkg::MagW'($urandom_range(int'(thr_up), int'(thr_down)));
        else if (want_high)
          mag = (thr_down < cwkd_pkg::MagMax) ?
                cwkd_pkg::MagW'($urandom_range(int'(thr_down) + 1, 4095)) : cwkd_pkg::MagMax;
        else
          mag = (thr_up > 0) ? cwkd_pkg::MagW'($urandom_range(0, int'(thr_up) - 1)) : '0;
        send_sample(mag);
        sent++;
      end
      want_high = ~want_high;
    end
  endtask

  // interval receiver and checker
  initial begin
    int gap;
    interval_t exp_iv;
    m_axis_tready <= 1'b0;
    @(posedge clk_i);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
      intervals_seen++;
      if (pending_intervals.size() == 0) begin
        note_mismatch("unexpected interval, tdata", 0, 32'(m_axis_tdata));
      end else begin
        exp_iv = pending_intervals.pop_front();
        if (m_axis_tuser !== exp_iv.is_space)
          note_mismatch("is_space", 32'(exp_iv.is_space), 32'(m_axis_tuser));
        if (m_axis_tdata[14:0] !== exp_iv.duration)
          note_mismatch("duration", 32'(exp_iv.duration), 32'(m_axis_tdata[14:0]));
      end
    end
  end

  // hand-picked samples at the reset settings: edges of both thresholds, broken runs
  task automatic test_directed_edges();
    logic [cwkd_pkg::MagW-1:0] seq[$];
    seq = '{12'd0, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd2047, 12'd2046,
            12'd2046, 12'd2046, 12'd2046, 12'd100, 12'd101, 12'd101, 12'd0, 12'd101,
            12'd101, 12'd101, 12'd101, 12'd50, 12'd49, 12'd49, 12'd49, 12'd49};
    foreach (seq[i]) send_sample(seq[i]);
    wait_intervals_drained();
  endtask

  // long space and then long mark interval with back-to-back samples
  task automatic test_long_intervals();
    int guard;
    no_idle = 1'b1;
    program_reg(cwkd_pkg::REG_FLOOR, 32'd100);
    program_reg(cwkd_pkg::REG_PERSIST, 32'd1);
    guard = 0;
    while (key_is_down && guard < 1000) begin
      send_sample('0);
      guard++;
    end
    repeat (150) send_sample('0);
    send_sample(cwkd_pkg::MagMax);
    repeat (150) send_sample(cwkd_pkg::MagMax);
    send_sample('0);
    wait_intervals_drained();
    no_idle = 1'b0;
  endtask

  // long window cut short by a floor change, so the new threshold saturates
  task automatic test_window_cut_short();
    int guard;
    program_reg(cwkd_pkg::REG_FLOOR, 32'd100);
    program_reg(cwkd_pkg::REG_PERSIST, 32'd4);
    guard = 0;
    while (thr_down <= floor_reg && guard < 300) begin
      send_sample(cwkd_pkg::MagMax);
      guard++;
    end
    guard = 0;
    while (win_cnt != cwkd_pkg::CountW'(150) && guard < 300) begin
      send_sample(cwkd_pkg::MagMax);
      guard++;
    end
    wait_intervals_drained();
    program_reg(cwkd_pkg::REG_FLOOR, 32'(thr_down));
    repeat (6) send_sample(cwkd_pkg::MagMax);
    repeat (6) send_sample('0);
    wait_intervals_drained();
  endtask

  // zero and maximum register values, masking of the upper data bits
  task automatic test_register_extremes();
    program_reg(cwkd_pkg::REG_FLOOR, {20'($urandom_range(0, 32'hF_FFFF)), 12'h000});
    program_reg(cwkd_pkg::REG_PERSIST, {24'($urandom_range(0, 32'hFF_FFFF)), 8'h00});
    send_keyed_runs(24, 10);
    wait_intervals_drained();
    program_reg(cwkd_pkg::REG_FLOOR, 32'hFFFF_FFFF);
    program_reg(cwkd_pkg::REG_PERSIST, 32'd1);
    send_keyed_runs(24, 10);
    wait_intervals_drained();
    program_reg(cwkd_pkg::REG_FLOOR, 32'd1);
    program_reg(cwkd_pkg::REG_PERSIST, 32'hFFFF_FFFF);
    repeat (270) send_sample(cwkd_pkg::MagMax);
    repeat (270) send_sample('0);
    wait_intervals_drained();
  endtask

  // random settings per phase, keyed runs with random content and noise
  task automatic test_random_keying();
    int phase;
    int sel;
    logic [31:0] fl;
    logic [31:0] pc;
    for (phase = 0; phase < 13; phase++) begin
      sel = $urandom_range(0, 99);
      if (phase == 0) fl = 32'd1;
      else if (phase == 1) fl = 32'd4095;
      else if (sel < 70) fl = $urandom_range(1, 300);
      else fl = $urandom_range(1, 4095);
      if (phase == 2) pc = 32'd0;
      else if (phase == 0) pc = 32'd1;
      else if ($urandom_range(0, 3) == 0) pc = $urandom_range(1, 20);
      else pc = $urandom_range(0, 6);
      case ($urandom_range(0, 3))
        0: program_reg(cwkd_pkg::REG_FLOOR, fl);
        1: program_reg(cwkd_pkg::REG_PERSIST, pc);
        default: begin
          program_reg(cwkd_pkg::REG_FLOOR, fl);
          program_reg(cwkd_pkg::REG_PERSIST, pc);
        end
      endcase
      no_idle = (phase % 4 == 3);
      send_keyed_runs(32, $urandom_range(0, 25));
      // sender holds off until everything so far has come out
      if (phase == 6) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
        while (pending_intervals.size() != 0) @(posedge clk_i);
      end
      send_keyed_runs(32, $urandom_range(0, 25));
      wait_intervals_drained();
    end
    no_idle = 1'b0;
  endtask

  // main sequence
  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    no_idle       = 1'b0;
    mismatches    = 0;
    items_sent    = 0;
    intervals_seen = 0;
    reg_writes    = 0;
    reset_tracker();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_edges();
    test_long_intervals();
    test_window_cut_short();
    test_register_extremes();
    test_random_keying();

    wait_intervals_drained();
    $display("sent %0d magnitude items, checked %0d intervals, %0d register writes",
             items_sent, intervals_seen, reg_writes);
    $display("covered threshold edges, floor and persist extremes, window cut, long intervals");
    if (mismatches == 0 && pending_intervals.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d intervals missing", mismatches, pending_intervals.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
